[rtl/sha_pkg.sv]
package sha_pkg;

    localparam int unsigned NumRounds = 64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Operation passed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_PAD_BYTE,
        OP_FINISH
    } sha_op_t;

    typedef struct packed {
        sha_op_t    op;
        logic [7:0] data;
    } sha_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } sha_state_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadMark = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_if.sv]
interface sha_in_if
    import sha_pkg::*;
();
    logic    valid;
    logic    ready;
    sha_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if
    import sha_pkg::*;
();
    logic     valid;
    logic     ready;
    sha_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/sha_front.sv]
module sha_front
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha_in_if.sink      in_ch,
    output logic        cmd_valid,
    output sha_cmd_t    cmd,
    input  logic        cmd_ready
);

    // A request with a byte and the last mark yields two commands; the
    // second is held here.
    logic pend_reg;
    logic pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        cmd_valid = 1'b0;
        cmd.op    = OP_BYTE;
        cmd.data  = in_ch.payload.data_byte;
        in_ch.ready = 1'b0;
        if (pend_reg)
        begin
            cmd_valid   = 1'b1;
            cmd.op      = OP_FINISH;
            in_ch.ready = cmd_ready;
            if (cmd_ready)
            begin
                pend_next = 1'b0;
            end
        end
        else if (in_ch.payload.byte_valid)
        begin
            cmd_valid = in_ch.valid;
            in_ch.ready = cmd_ready && !in_ch.payload.last_byte;
            if (in_ch.valid && cmd_ready && in_ch.payload.last_byte)
            begin
                pend_next = 1'b1;
            end
        end
        else
        begin
            cmd_valid   = in_ch.valid && in_ch.payload.last_byte;
            cmd.op      = OP_FINISH;
            in_ch.ready = cmd_ready || !in_ch.payload.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

[rtl/sha_queue.sv]
module sha_queue
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    input  sha_cmd_t wr_cmd,
    output logic     wr_ready,
    output logic     rd_valid,
    output sha_cmd_t rd_cmd,
    input  logic     rd_ready
);

    sha_cmd_t   mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    logic push;
    logic pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/sha_back.sv]
module sha_back
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  sha_cmd_t cmd,
    output logic     cmd_ready,
    sha_out_if.source out_ch
);

    sha_state_t  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;     // finishing: padding in progress
    logic        lenblk_reg, lenblk_next; // padding block carries length
    logic [2:0]  oidx_reg, oidx_next;
    logic        ovalid_reg;
    logic [31:0] oword_reg;
    logic [2:0]  oindex_reg;

    logic        take;
    logic        st_byte;      // store a byte into the block buffer
    logic [7:0]  st_data;
    logic        st_len;
    logic        do_round;
    logic        do_add;
    logic        do_init;
    logic        load_out;
    logic        out_free;

    logic [31:0] wt, wnew, s0, s1, t1, t2, ch, mj, e1, e0;
    logic [31:0] wm2, wm7, wm15, wm16;
    logic [3:0]  ti;

    assign out_free = !ovalid_reg || out_ch.ready;

    always_comb
    begin
        ti   = rnd_reg[3:0];
        wm2  = w_reg[4'(ti - 4'd2)];
        wm7  = w_reg[4'(ti - 4'd7)];
        wm15 = w_reg[4'(ti - 4'd15)];
        wm16 = w_reg[ti];
        s1   = rotr(wm2, 17) ^ rotr(wm2, 19) ^ (wm2 >> 10);
        s0   = rotr(wm15, 7) ^ rotr(wm15, 18) ^ (wm15 >> 3);
        wnew = s1 + wm7 + s0 + wm16;
        wt   = (rnd_reg >= 6'd16) ? wnew : wm16;
        e1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        e0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + e1 + ch + round_const(rnd_reg) + wt;
        t2   = e0 + mj;
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        rnd_next    = rnd_reg;
        fin_next    = fin_reg;
        lenblk_next = lenblk_reg;
        oidx_next   = oidx_reg;
        cmd_ready   = 1'b0;
        take        = 1'b0;
        st_byte     = 1'b0;
        st_data     = cmd.data;
        st_len      = 1'b0;
        do_round    = 1'b0;
        do_add      = 1'b0;
        do_init     = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (fin_reg)
                begin
                    // Padding: zeros up to the length field or block end.
                    st_byte = 1'b1;
                    st_data = 8'h00;
                    if (lenblk_reg && fill_reg == 6'd56)
                    begin
                        st_byte   = 1'b0;
                        st_len    = 1'b1;
                        fill_next = 6'd0;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_ROUND;
                        end
                    end
                end
                else
                begin
                    cmd_ready = 1'b1;
                    take      = cmd_valid;
                    if (take)
                    begin
                        st_byte   = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        if (cmd.op == OP_BYTE)
                        begin
                            bits_next = bits_reg + 64'd8;
                            if (fill_reg == 6'd63)
                            begin
                                state_next = ST_ROUND;
                            end
                        end
                        else
                        begin
                            st_data     = PadMark;
                            fin_next    = 1'b1;
                            lenblk_next = (fill_reg < 6'd56);
                            if (fill_reg == 6'd63)
                            begin
                                state_next = ST_ROUND;
                            end
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                do_round = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(NumRounds - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                do_add = 1'b1;
                if (fin_reg && lenblk_reg)
                begin
                    state_next = ST_EMIT;
                    oidx_next  = 3'd0;
                end
                else
                begin
                    // After the first of two padding blocks the next one
                    // carries the length.
                    if (fin_reg)
                    begin
                        lenblk_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        do_init     = 1'b1;
                        fin_next    = 1'b0;
                        lenblk_next = 1'b0;
                        bits_next   = 64'd0;
                        fill_next   = 6'd0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Block buffer, schedule, working set and output word.
    always_ff @(posedge clk)
    begin
        if (st_byte)
        begin
            case (fill_reg[1:0])
                2'd0:    w_reg[fill_reg[5:2]][31:24] <= st_data;
                2'd1:    w_reg[fill_reg[5:2]][23:16] <= st_data;
                2'd2:    w_reg[fill_reg[5:2]][15:8]  <= st_data;
                default: w_reg[fill_reg[5:2]][7:0]   <= st_data;
            endcase
        end
        if (st_len)
        begin
            w_reg[14] <= bits_reg[63:32];
            w_reg[15] <= bits_reg[31:0];
        end
        if (state_reg != ST_ROUND && state_next == ST_ROUND)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (do_round)
        begin
            w_reg[ti] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (load_out)
        begin
            oword_reg  <= h_reg[oidx_reg];
            oindex_reg <= oidx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[255 - 32 * i -: 32];
            end
        end
        else if (do_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (do_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[255 - 32 * i -: 32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            bits_reg   <= 64'd0;
            rnd_reg    <= 6'd0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            rnd_reg    <= rnd_next;
            fin_reg    <= fin_next;
            lenblk_reg <= lenblk_next;
            oidx_reg   <= oidx_next;
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid               = ovalid_reg;
    assign out_ch.payload.digest_word = oword_reg;
    assign out_ch.payload.word_index  = oindex_reg;
    assign out_ch.payload.last_word   = (oindex_reg == 3'd7);

    a_round_only_in_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg != 6'd0 || $past(state_reg) != ST_ROUND))
        else $error("round counter did not start from zero");
    a_no_take_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !take)
        else $error("command taken during padding");
    a_emit_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (fin_reg && lenblk_reg))
        else $error("digest emitted outside final block");

endmodule

[rtl/sha256_hash_engine.sv]
// Channel   Dir  Payload                                  Notes
// in_ch     in   data_byte, byte_valid, last_byte         one request per message byte
// out_ch    out  digest_word, word_index, last_word       eight requests per message
//
// A byte request passes through the command queue into the block buffer; the 64th
// byte of a block starts the rounds, followed by the chaining addition.
// The last request adds the padding one byte per cycle, then one or two more
// blocks of rounds, then eight output requests at one per cycle when taken.
// Reset (rst_n low) restores the initial hash values and empties the queue.
// The two-entry command queue lets the front take requests while the rounds run.
module sha256_hash_engine
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);

    // Commands classified by the front part travel through a short queue
    // to the back part, which holds the block buffer and the round unit.
    logic     fq_valid;
    sha_cmd_t fq_cmd;
    logic     fq_ready;
    logic     qb_valid;
    sha_cmd_t qb_cmd;
    logic     qb_ready;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (fq_valid),
        .cmd       (fq_cmd),
        .cmd_ready (fq_ready)
    );

    sha_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_cmd   (fq_cmd),
        .wr_ready (fq_ready),
        .rd_valid (qb_valid),
        .rd_cmd   (qb_cmd),
        .rd_ready (qb_ready)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd       (qb_cmd),
        .cmd_ready (qb_ready),
        .out_ch    (out_ch)
    );

endmodule
